@@ rtl/bas_pkg.sv @@
package bas_pkg;

  localparam int POOL_ORDER   = 16;
  localparam int MIN_ORDER    = 5;
  localparam int HEADER_BYTES = 24;
  localparam int SLAB32_COUNT = 256;
  localparam int SLAB64_COUNT = 256;

  localparam int GRAN_W      = POOL_ORDER - MIN_ORDER;
  localparam int GRANULES    = 1 << GRAN_W;
  localparam int NORDERS     = GRAN_W + 1;
  localparam int K_W         = $clog2(NORDERS);
  localparam int CNT_W       = GRAN_W + 1;
  localparam int ORD_W       = 5;
  localparam int SMALL_TOTAL = SLAB32_COUNT + SLAB64_COUNT;
  localparam int SIDX_W      = $clog2(SMALL_TOTAL);
  localparam int S32_W       = $clog2(SLAB32_COUNT + 1);
  localparam int S64_W       = $clog2(SLAB64_COUNT + 1);
  localparam int SCNT_W      = (S32_W > S64_W) ? S32_W : S64_W;
  localparam int SLNK_W      = SCNT_W;

  localparam logic       MODE_ALLOC   = 1'b0;
  localparam logic       MODE_FREE    = 1'b1;
  localparam logic [1:0] REGION_S32   = 2'd0;
  localparam logic [1:0] REGION_S64   = 2'd1;
  localparam logic [1:0] REGION_POOL  = 2'd2;
  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_FAIL  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [23:0] req_size;
    logic [1:0]  free_region;
    logic [15:0] free_offset;
  } bas_in_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  region;
    logic [15:0] offset;
  } bas_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SMALL_RD,
    ST_SMALL_WR,
    ST_SEARCH,
    ST_POP_RD,
    ST_POP_WR,
    ST_SPLIT,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_WALK_INIT,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_UNLINK_RD,
    ST_UNLINK_WR,
    ST_PUSH,
    ST_DONE
  } bas_state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic small_rd;
    logic small_pop;
    logic small_push;
    logic search_step;
    logic pop_rd;
    logic pop_wr;
    logic split_push;
    logic free_rd;
    logic free_setup;
    logic walk_init;
    logic walk_rd;
    logic walk_adv;
    logic unlink_rd;
    logic unlink_wr;
    logic merge_up;
    logic final_push;
    logic res_fail;
    logic res_small;
    logic res_pool;
    logic res_free;
    logic emit;
  } bas_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clearing;
    logic is_free;
    logic free_small;
    logic free_pool;
    logic size_zero;
    logic use_s32;
    logic use_s64;
    logic pool_too_big;
    logic search_hit;
    logic search_end;
    logic split_more;
    logic free_bad;
    logic at_top;
    logic walk_empty;
    logic walk_match;
    logic walk_last;
  } bas_sts_t;

endpackage

@@ rtl/buddy_allocator_with_slabs.sv @@
// Buddy allocator with 32-byte and 64-byte slab front ends.
// Input: raise start with in_data while busy is low; the beat is taken
// on that edge and busy stays high through the cycle showing the result.
// Allocate (mode 0) tries slab32, slab64, then the buddy pool; free
// (mode 1) returns a block to its region and merges pool buddies.
// Result: out_valid is high for one cycle with out_data; there is no
// backpressure, the receiver must take it then.
// Pool allocate searches upward from the needed order for a free block,
// pops it and splits it down to that order; a pool free walks the
// order's free list for the buddy, one link per WALK_RD and WALK_CMP
// pair, and merges while the buddy is found.
// busy drops in the cycle after the result, so a new beat is taken only
// after the previous result. One item is in flight at a time.
// Reset (rst_n low, synchronous) restores a single free top-order block
// and full slab lists; a pass over every slab link entry then fills the
// slab link memory with busy held high.
module buddy_allocator_with_slabs import bas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bas_in_t  in_data,
  output logic     out_valid,
  output bas_out_t out_data
);

  bas_cmd_t cmd;
  bas_sts_t sts;

  bas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bas_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/bas_ctrl.sv @@
module bas_ctrl import bas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bas_sts_t sts,
  output bas_cmd_t cmd
);

  bas_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE) || sts.clearing;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start && !sts.clearing) begin
          cmd.latch_in = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_free) begin
          if (sts.free_small) begin
            cmd.small_push = 1'b1;
            cmd.res_free = 1'b1;
            state_nxt = ST_DONE;
          end else if (sts.free_pool) begin
            cmd.free_rd = 1'b1;
            state_nxt = ST_FREE_RD;
          end else begin
            cmd.res_free = 1'b1;
            state_nxt = ST_DONE;
          end
        end else if (sts.size_zero) begin
          cmd.res_fail = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.use_s32 || sts.use_s64) begin
          cmd.small_rd = 1'b1;
          state_nxt = ST_SMALL_RD;
        end else if (sts.pool_too_big) begin
          cmd.res_fail = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SMALL_RD: begin
        state_nxt = ST_SMALL_WR;
      end
      ST_SMALL_WR: begin
        cmd.small_pop = 1'b1;
        cmd.res_small = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SEARCH: begin
        if (sts.search_hit) begin
          cmd.pop_rd = 1'b1;
          state_nxt = ST_POP_RD;
        end else if (sts.search_end) begin
          cmd.res_fail = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_WR;
      end
      ST_POP_WR: begin
        cmd.pop_wr = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts.split_more) begin
          cmd.split_push = 1'b1;
        end else begin
          cmd.res_pool = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (sts.free_bad) begin
          cmd.res_free = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.free_setup = 1'b1;
          state_nxt = ST_WALK_INIT;
        end
      end
      ST_WALK_INIT: begin
        if (sts.at_top || sts.walk_empty) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt = ST_WALK_CMP;
        end
      end
      ST_WALK_CMP: begin
        if (sts.walk_match) begin
          cmd.unlink_rd = 1'b1;
          state_nxt = ST_UNLINK_RD;
        end else if (sts.walk_last) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cmd.walk_adv = 1'b1;
        state_nxt = ST_WALK_CMP;
      end
      ST_UNLINK_RD: begin
        state_nxt = ST_UNLINK_WR;
      end
      ST_UNLINK_WR: begin
        cmd.unlink_wr = 1'b1;
        cmd.merge_up = 1'b1;
        state_nxt = ST_WALK_INIT;
      end
      ST_PUSH: begin
        cmd.final_push = 1'b1;
        cmd.res_free = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bas_dp.sv @@
module bas_dp import bas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bas_in_t  in_data,
  input  bas_cmd_t cmd,
  output bas_sts_t sts,
  output logic     out_valid,
  output bas_out_t out_data
);

  // free-list heads, counts and availability
  logic [GRAN_W-1:0] heads_r [NORDERS];
  logic [CNT_W-1:0]  counts_r [NORDERS];
  logic [NORDERS-1:0] avail_r;

  logic [GRAN_W-1:0] glink_mem [GRANULES];
  logic [ORD_W-1:0]  gord_mem [GRANULES];
  logic [GRAN_W-1:0] glink_rd_r;
  logic [ORD_W-1:0]  gord_rd_r;

  logic [SLNK_W-1:0] slink_mem [SMALL_TOTAL];
  logic [SLNK_W-1:0] slink_rd_r;
  logic [SLNK_W-1:0] sheads_r [2];
  logic [SCNT_W-1:0] scount_r [2];

  // slab link fill after reset
  logic [SIDX_W-1:0] clr_idx_r;
  logic              clr_busy_r;
  logic [SLNK_W-1:0] clr_val;

  bas_in_t in_r;
  logic [K_W-1:0] k_r, want_r;
  logic [GRAN_W-1:0] g_r, cur_r, prev_r;
  logic [CNT_W-1:0] walk_i_r;
  logic             sel64_r;
  logic [ORD_W-1:0] order_r;
  logic             out_valid_r;
  bas_out_t         out_r;

  logic [24:0] cap;
  logic [ORD_W-1:0] need_order;
  logic [16:0] rel;
  logic [GRAN_W-1:0] buddy;
  logic [GRAN_W-1:0] fgran;
  logic [ORD_W-1:0] fk;
  logic small_ok32, small_ok64;
  logic [SIDX_W-1:0] sidx_base;
  logic [SIDX_W-1:0] push_idx;
  logic [15:0] push_idx_w;
  logic [SCNT_W-1:0] cap_sel;
  logic push_r;

  always_comb begin
    cap = {1'b0, in_r.req_size} + 25'(HEADER_BYTES);
    need_order = ORD_W'(MIN_ORDER);
    for (int o = POOL_ORDER; o >= MIN_ORDER; o--) begin
      if (cap <= (25'd1 << o)) need_order = ORD_W'(o);
    end
  end

  assign small_ok32 = (scount_r[0] != '0);
  assign small_ok64 = (scount_r[1] != '0);
  assign rel    = {1'b0, in_r.free_offset} - 17'(HEADER_BYTES);
  assign fgran  = rel[MIN_ORDER +: GRAN_W];
  assign fk     = gord_rd_r - ORD_W'(MIN_ORDER);
  assign buddy  = g_r ^ (GRAN_W'(1) << k_r);
  assign push_r = (in_r.free_region == REGION_S64);
  assign push_idx_w = push_r ? (in_r.free_offset >> 6) : (in_r.free_offset >> 5);
  assign cap_sel = push_r ? SCNT_W'(SLAB64_COUNT) : SCNT_W'(SLAB32_COUNT);
  // each list links index i to i + 1
  assign clr_val = (clr_idx_r < SIDX_W'(SLAB32_COUNT))
                 ? SLNK_W'(clr_idx_r) + 1'b1
                 : SLNK_W'(clr_idx_r - SIDX_W'(SLAB32_COUNT)) + 1'b1;

  always_comb begin
    sts = '0;
    sts.clearing   = clr_busy_r;
    sts.is_free    = (in_r.mode == MODE_FREE);
    sts.free_small = (in_r.free_region == REGION_S32) || (in_r.free_region == REGION_S64);
    sts.free_pool  = (in_r.free_region == REGION_POOL);
    sts.size_zero  = (in_r.req_size == '0);
    sts.use_s32    = (in_r.req_size <= 24'd32) && small_ok32;
    sts.use_s64    = (in_r.req_size <= 24'd64) && small_ok64;
    sts.pool_too_big = (cap > (25'd1 << POOL_ORDER));
    sts.search_hit = avail_r[k_r];
    sts.search_end = (k_r == K_W'(NORDERS - 1));
    sts.split_more = (k_r > want_r);
    sts.free_bad   = (in_r.free_offset < 16'(HEADER_BYTES))
                  || (rel[MIN_ORDER-1:0] != '0)
                  || (rel[16:MIN_ORDER] >= 17'(GRANULES))
                  || (gord_rd_r < ORD_W'(MIN_ORDER))
                  || (gord_rd_r > ORD_W'(POOL_ORDER))
                  || ((fgran & ((GRAN_W'(1) << fk[K_W-1:0]) - 1'b1)) != '0);
    sts.at_top     = (k_r == K_W'(NORDERS - 1));
    sts.walk_empty = (counts_r[k_r] == '0);
    sts.walk_match = (cur_r == buddy);
    sts.walk_last  = (walk_i_r + 1'b1 >= counts_r[k_r]);
  end

  // slab index selection
  always_comb begin
    sidx_base = '0;
    push_idx = '0;
    if (!sts.use_s32) sidx_base = SIDX_W'(SLAB32_COUNT) + SIDX_W'(sheads_r[1]);
    else sidx_base = SIDX_W'(sheads_r[0]);
    push_idx = push_r ? (SIDX_W'(SLAB32_COUNT) + SIDX_W'(push_idx_w))
                      : SIDX_W'(push_idx_w);
  end

  // slab link store
  always_ff @(posedge clk) begin
    if (cmd.small_rd) slink_rd_r <= slink_mem[sidx_base];
    if (clr_busy_r) slink_mem[clr_idx_r] <= clr_val;
    if (cmd.small_push && (push_idx_w < 16'(cap_sel))
        && (scount_r[push_r] < cap_sel)) begin
      slink_mem[push_idx] <= sheads_r[push_r];
    end
  end

  // granule stores
  always_ff @(posedge clk) begin
    if (cmd.pop_rd) glink_rd_r <= glink_mem[heads_r[k_r]];
    if (cmd.walk_rd || cmd.walk_init) glink_rd_r <= glink_mem[cmd.walk_init ? heads_r[k_r] : cur_r];
    if (cmd.unlink_rd) glink_rd_r <= glink_mem[cur_r];
    if (cmd.free_rd) gord_rd_r <= gord_mem[fgran];
    if (cmd.split_push && counts_r[k_r - 1'b1] < CNT_W'(GRANULES))
      glink_mem[g_r ^ (GRAN_W'(1) << (k_r - 1'b1))] <= heads_r[k_r - 1'b1];
    if (cmd.final_push && counts_r[k_r] < CNT_W'(GRANULES))
      glink_mem[g_r] <= heads_r[k_r];
    if (cmd.unlink_wr && walk_i_r != '0) glink_mem[prev_r] <= glink_rd_r;
    if (cmd.res_pool) gord_mem[g_r] <= ORD_W'(MIN_ORDER) + ORD_W'(want_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) in_r <= in_data;
    if (cmd.free_rd) begin
      // offset after header comes from the combinational rel
    end
    case (1'b1)
      cmd.latch_in: begin
        k_r <= '0;
      end
      default: ;
    endcase
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avail_r <= NORDERS'(1) << (NORDERS - 1);
      for (int i = 0; i < NORDERS; i++) begin
        heads_r[i] <= '0;
        counts_r[i] <= (i == NORDERS - 1) ? CNT_W'(1) : '0;
      end
      sheads_r[0] <= '0;
      sheads_r[1] <= '0;
      scount_r[0] <= SCNT_W'(SLAB32_COUNT);
      scount_r[1] <= SCNT_W'(SLAB64_COUNT);
      clr_idx_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      // result shows in the DONE cycle, while busy is still high
      out_valid_r <= cmd.res_fail | cmd.res_free | cmd.res_small | cmd.res_pool;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == SIDX_W'(SMALL_TOTAL - 1)) clr_busy_r <= 1'b0;
      end
      if (cmd.small_rd) begin
        sel64_r <= !sts.use_s32;
      end
      if (cmd.small_pop) begin
        sheads_r[sel64_r] <= slink_rd_r;
        scount_r[sel64_r] <= scount_r[sel64_r] - 1'b1;
      end
      if (cmd.small_push && (push_idx_w < 16'(cap_sel))
          && (scount_r[push_r] < cap_sel)) begin
        sheads_r[push_r] <= SLNK_W'(push_idx_w);
        scount_r[push_r] <= scount_r[push_r] + 1'b1;
      end
      if (in_r.mode == MODE_ALLOC && !cmd.latch_in && !cmd.search_step
          && !cmd.pop_rd && !cmd.pop_wr && !cmd.split_push && !cmd.small_rd
          && !cmd.small_pop && !cmd.res_fail && !cmd.res_pool && !cmd.emit
          && order_r != need_order) begin
        order_r <= need_order;
        k_r <= K_W'(need_order - ORD_W'(MIN_ORDER));
        want_r <= K_W'(need_order - ORD_W'(MIN_ORDER));
      end
      if (cmd.latch_in) order_r <= '0;
      if (cmd.search_step) k_r <= k_r + 1'b1;
      if (cmd.pop_wr) begin
        g_r <= heads_r[k_r];
        heads_r[k_r] <= glink_rd_r;
        counts_r[k_r] <= counts_r[k_r] - 1'b1;
        if (counts_r[k_r] == CNT_W'(1)) avail_r[k_r] <= 1'b0;
      end
      if (cmd.split_push) begin
        k_r <= k_r - 1'b1;
        if (counts_r[k_r - 1'b1] < CNT_W'(GRANULES)) begin
          heads_r[k_r - 1'b1] <= g_r ^ (GRAN_W'(1) << (k_r - 1'b1));
          counts_r[k_r - 1'b1] <= counts_r[k_r - 1'b1] + 1'b1;
          avail_r[k_r - 1'b1] <= 1'b1;
        end
      end
      if (cmd.free_setup) begin
        g_r <= fgran;
        k_r <= fk[K_W-1:0];
      end
      if (cmd.walk_init) begin
        cur_r <= heads_r[k_r];
        walk_i_r <= '0;
      end
      if (cmd.walk_adv) begin
        prev_r <= cur_r;
        cur_r <= glink_rd_r;
        walk_i_r <= walk_i_r + 1'b1;
      end
      if (cmd.unlink_wr) begin
        if (walk_i_r == '0) heads_r[k_r] <= glink_rd_r;
        counts_r[k_r] <= counts_r[k_r] - 1'b1;
        if (counts_r[k_r] == CNT_W'(1)) avail_r[k_r] <= 1'b0;
        if (buddy < g_r) g_r <= buddy;
        k_r <= k_r + 1'b1;
      end
      if (cmd.final_push && counts_r[k_r] < CNT_W'(GRANULES)) begin
        heads_r[k_r] <= g_r;
        counts_r[k_r] <= counts_r[k_r] + 1'b1;
        avail_r[k_r] <= 1'b1;
      end
    end
    if (cmd.res_fail) out_r <= '{status: STATUS_FAIL, region: REGION_S32, offset: '0};
    if (cmd.res_free) out_r <= '{status: STATUS_OK, region: REGION_S32, offset: '0};
    if (cmd.res_small) begin
      out_r.status <= STATUS_OK;
      out_r.region <= sel64_r ? REGION_S64 : REGION_S32;
      out_r.offset <= sel64_r ? 16'({sheads_r[1], 6'd0}) : 16'({sheads_r[0], 5'd0});
    end
    if (cmd.res_pool) begin
      out_r.status <= STATUS_OK;
      out_r.region <= REGION_POOL;
      out_r.offset <= 16'({g_r, MIN_ORDER'(0)}) + 16'(HEADER_BYTES);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/bas_chk.sv @@
module bas_chk import bas_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input bas_out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("no busy after accept");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STATUS_FAIL) |->
      (out_data.region == REGION_S32 && out_data.offset == '0))
    else $error("fail result carries address");

endmodule

bind buddy_allocator_with_slabs bas_chk u_bas_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ tb/buddy_allocator_with_slabs_tb.sv @@
module buddy_allocator_with_slabs_tb;
  import bas_pkg::*;

  localparam int STALL_LIMIT = 200000;

  class alloc_scoreboard;
    int unsigned ord_head[NORDERS];
    int unsigned ord_cnt[NORDERS];
    int unsigned avail;
    int unsigned gran_link[GRANULES];
    int unsigned gran_ord[GRANULES];
    int unsigned slab_head[2];
    int unsigned slab_cnt[2];
    int unsigned slab_link[SMALL_TOTAL];
    bas_out_t    expected_q[$];
    int          mismatches;
    int          results_seen;

    function new();
      for (int k = 0; k < NORDERS; k++) begin
        ord_head[k] = 0;
        ord_cnt[k] = 0;
      end
      for (int g = 0; g < GRANULES; g++) begin
        gran_link[g] = 0;
        gran_ord[g] = 0;
      end
      ord_cnt[NORDERS-1] = 1;
      avail = 1 << (NORDERS - 1);
      for (int i = 0; i < SLAB32_COUNT; i++) slab_link[i] = i + 1;
      for (int i = 0; i < SLAB64_COUNT; i++) slab_link[SLAB32_COUNT+i] = i + 1;
      slab_head[0] = 0;
      slab_head[1] = 0;
      slab_cnt[0] = SLAB32_COUNT;
      slab_cnt[1] = SLAB64_COUNT;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void list_push(int unsigned k, int unsigned g);
      if (ord_cnt[k] >= GRANULES) return;
      gran_link[g] = ord_head[k];
      ord_head[k] = g;
      ord_cnt[k]++;
      avail |= 1 << k;
    endfunction

    function int unsigned list_pop(int unsigned k);
      int unsigned g;
      g = ord_head[k];
      ord_head[k] = gran_link[g];
      ord_cnt[k]--;
      if (ord_cnt[k] == 0) avail &= ~(1 << k);
      return g;
    endfunction

    // unlink buddy b from order k; walks at most the list length
    function bit list_unlink(int unsigned k, int unsigned b);
      int unsigned n, cur, prev;
      n = ord_cnt[k];
      cur = ord_head[k];
      prev = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (cur == b) begin
          if (i == 0) ord_head[k] = gran_link[cur];
          else gran_link[prev] = gran_link[cur];
          ord_cnt[k]--;
          if (ord_cnt[k] == 0) avail &= ~(1 << k);
          return 1;
        end
        prev = cur;
        cur = gran_link[cur] & (GRANULES - 1);
      end
      return 0;
    endfunction

    function void slab_release(int unsigned r, int unsigned idx);
      int unsigned base, cap;
      base = r ? SLAB32_COUNT : 0;
      cap = r ? SLAB64_COUNT : SLAB32_COUNT;
      if (idx >= cap || slab_cnt[r] >= cap) return;
      slab_link[base+idx] = slab_head[r];
      slab_head[r] = idx;
      slab_cnt[r]++;
    endfunction

    function void pool_release(int unsigned off);
      int unsigned rel, g, ord, k, bud;
      if (off < HEADER_BYTES) return;
      rel = off - HEADER_BYTES;
      if ((rel & ((1 << MIN_ORDER) - 1)) != 0) return;
      g = rel >> MIN_ORDER;
      if (g >= GRANULES) return;
      ord = gran_ord[g];
      if (ord < MIN_ORDER || ord > POOL_ORDER) return;
      k = ord - MIN_ORDER;
      if ((g & ((1 << k) - 1)) != 0) return;
      forever begin
        if (k == NORDERS - 1) begin
          list_push(k, g);
          return;
        end
        bud = g ^ (1 << k);
        if (!list_unlink(k, bud)) begin
          list_push(k, g);
          return;
        end
        if (bud < g) g = bud;
        k++;
      end
    endfunction

    // computes the response to one accepted beat and queues it
    function bas_out_t note_input(bas_in_t b);
      bas_out_t  r;
      longint    need;
      int unsigned ord, want, k, g, idx;
      r = '0;
      if (b.mode == MODE_FREE) begin
        if (b.free_region == REGION_S32) slab_release(0, b.free_offset >> 5);
        else if (b.free_region == REGION_S64) slab_release(1, b.free_offset >> 6);
        else if (b.free_region == REGION_POOL) pool_release(b.free_offset);
      end else if (b.req_size == 0) begin
        r.status = STATUS_FAIL;
      end else if (b.req_size <= 32 && slab_cnt[0] != 0) begin
        idx = slab_head[0];
        slab_head[0] = slab_link[idx];
        slab_cnt[0]--;
        r.region = REGION_S32;
        r.offset = 16'(idx * 32);
      end else if (b.req_size <= 64 && slab_cnt[1] != 0) begin
        idx = slab_head[1];
        slab_head[1] = slab_link[SLAB32_COUNT+idx];
        slab_cnt[1]--;
        r.region = REGION_S64;
        r.offset = 16'(idx * 64);
      end else begin
        need = longint'(b.req_size) + HEADER_BYTES;
        ord = MIN_ORDER;
        while ((longint'(1) << ord) < need) ord++;
        r.status = STATUS_FAIL;
        if (ord <= POOL_ORDER) begin
          want = ord - MIN_ORDER;
          for (k = want; k < NORDERS; k++)
            if (avail[k]) break;
          if (k < NORDERS) begin
            g = list_pop(k);
            while (k > want) begin
              k--;
              list_push(k, g ^ (1 << k));
            end
            gran_ord[g] = ord;
            r.status = STATUS_OK;
            r.region = REGION_POOL;
            r.offset = 16'((g << MIN_ORDER) + HEADER_BYTES);
          end
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(bas_out_t got);
      bas_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.region !== want.region ||
          got.offset !== want.offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected st=%0d rg=%0d off=%0d, got st=%0d rg=%0d off=%0d",
                   want.status, want.region, want.offset,
                   got.status, got.region, got.offset);
      end
    endfunction
  endclass

  typedef struct {
    logic [1:0]  rg;
    logic [15:0] off;
  } block_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bas_in_t  in_data = '0;
  logic     out_valid;
  bas_out_t out_data;

  alloc_scoreboard sb = new();
  block_t  live_q[$];
  bit      gran_used[GRANULES];
  int      idle_pct = 0;
  int      stall_cnt = 0;
  int      n_alloc_ok = 0, n_alloc_fail = 0, n_free = 0;

  buddy_allocator_with_slabs dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("buddy_allocator_with_slabs_tb: FAIL");
      $finish;
    end
  end

  // leaves start high unless it idles at random (idle_pct); the caller either sends again or idles
  task automatic send(bas_in_t b);
    bas_out_t r;
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy !== 1'b0);
    r = sb.note_input(b);
    if (b.mode == MODE_FREE) n_free++;
    else if (r.status == STATUS_FAIL) n_alloc_fail++;
    else begin
      n_alloc_ok++;
      live_q.push_back('{r.region, r.offset});
      if (r.region == REGION_POOL) gran_used[(r.offset - HEADER_BYTES) >> MIN_ORDER] = 1;
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic do_alloc(int unsigned sz);
    bas_in_t b;
    b = '0;
    b.mode = MODE_ALLOC;
    b.req_size = 24'(sz);
    b.free_region = 2'($urandom_range(3));
    b.free_offset = 16'($urandom);
    send(b);
  endtask

  task automatic do_free(logic [1:0] rg, logic [15:0] off);
    bas_in_t b;
    b = '0;
    b.mode = MODE_FREE;
    b.req_size = 24'($urandom);
    b.free_region = rg;
    b.free_offset = off;
    send(b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 5) return 0;
    if (p < 25) return $urandom_range(1, 32);
    if (p < 45) return $urandom_range(33, 64);
    if (p < 80) return $urandom_range(65, 2000);
    if (p < 94) return $urandom_range(2001, 70000);
    return $urandom_range(24'hFFFFFF);
  endfunction

  task automatic random_beat(int alloc_pct);
    int unsigned i, g;
    block_t      blk;
    logic [15:0] off;
    logic [1:0]  rg;
    if ($urandom_range(99) < alloc_pct) begin
      do_alloc(pick_size());
    end else if (live_q.size() != 0 && $urandom_range(99) < 88) begin
      i = $urandom_range(live_q.size() - 1);
      blk = live_q[i];
      // occasionally keep it so it gets freed twice
      if ($urandom_range(99) >= 4) live_q.delete(i);
      do_free(blk.rg, blk.off);
    end else begin
      rg = 2'($urandom_range(3));
      off = 16'($urandom);
      if (rg == REGION_POOL && off >= HEADER_BYTES &&
          ((off - HEADER_BYTES) & 16'h1F) == 0) begin
        g = (off - HEADER_BYTES) >> MIN_ORDER;
        if (!gran_used[g]) off = off | 16'h1;
      end
      do_free(rg, off);
    end
  endtask

  initial begin
    int alloc_pct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: slab edges, pool limits, bad and repeated frees
    do_alloc(0);
    do_alloc(1);
    do_alloc(32);
    do_alloc(33);
    do_alloc(64);
    do_alloc(65);
    do_free(2'd3, 16'd0);
    do_free(REGION_S32, 16'hFFFF);
    do_free(REGION_S64, 16'hFFC0);
    do_free(REGION_S32, 16'd0);
    do_free(REGION_S32, 16'd0);
    do_alloc(65512);
    do_free(REGION_POOL, 16'(HEADER_BYTES));
    do_alloc(65512);
    do_alloc(65513);
    do_alloc(24'hFFFFFF);
    do_alloc(100);
    do_free(REGION_POOL, 16'(HEADER_BYTES));
    do_free(REGION_POOL, 16'(HEADER_BYTES));
    do_free(REGION_POOL, 16'd5);
    do_free(REGION_POOL, 16'(HEADER_BYTES + 16));
    do_alloc(1000);
    // hold off until the block has answered everything
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 80;
        2: idle_pct = 0;
        default: idle_pct = 20;
      endcase
      for (int n = 0; n < 400; n++) begin
        // swing between filling and emptying the stores
        alloc_pct = ((n / 100) % 2 == 0) ? 70 : 35;
        random_beat(alloc_pct);
      end
      if (ph == 1) drain();
    end

    start <= 1'b0;
    for (int w = 0; w < 200000 && sb.expected_q.size() != 0; w++) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0d results never arrived", sb.expected_q.size());
      sb.mismatches++;
    end
    $display("covered %0d allocations granted, %0d refused, %0d frees; %0d results checked",
             n_alloc_ok, n_alloc_fail, n_free, sb.results_seen);
    $display("mismatch count: %0d", sb.mismatches);
    if (sb.mismatches == 0) $display("buddy_allocator_with_slabs_tb: PASS");
    else $display("buddy_allocator_with_slabs_tb: FAIL");
    $finish;
  end

endmodule
